### sv/plv_pkg.sv
// Shared types, constants and state encoding for the patch label vote block.
package plv_pkg;

	// Fixed field widths of the request and result items
	localparam int LABEL_W = 6;
	localparam int COUNT_OUT_W = 11;
	localparam int RATIO_W = 16;
	localparam int RATIO_FRAC_W = 8;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd256;

	// Default sizes handed to the top level
	localparam int NUM_LABELS_DEF = 64;
	localparam int MAX_PATCH_PIXELS_DEF = 1024;

	// Queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic               last_pixel;
		logic [LABEL_W-1:0] query_label;
	} plv_pix_t;

	typedef struct packed {
		logic [LABEL_W-1:0]     top_label;
		logic                   ratio_pass;
		logic                   query_present;
		logic [COUNT_OUT_W-1:0] top_count;
	} plv_res_t;

	// Classified request as it sits in the queue
	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic               hit;
		logic               last;
		logic [LABEL_W-1:0] query;
		logic               query_hit;
	} plv_entry_t;

	typedef enum logic [2:0] {
		ST_COUNT,
		ST_LASTW,
		ST_SCAN,
		ST_TAIL,
		ST_MUL,
		ST_EMIT
	} plv_state_t;

endpackage

### sv/plv_front.sv
// Front part: classifies incoming pixel requests and queues them for the back part.
module plv_front #(
	parameter int NUM_LABELS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  plv_pkg::plv_pix_t   pix,
	output logic                q_vld,
	output plv_pkg::plv_entry_t q_head,
	input  logic                pop
);
	import plv_pkg::*;

	plv_entry_t              fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q;
	logic [QPTR_W-1:0]       rd_ptr_q;
	logic [QCNT_W-1:0]       cnt_q;
	plv_entry_t              ent;
	logic                    push;
	logic                    do_pop;

	// Classify: flag labels that fall inside the histogram
	always_comb begin
		ent.label = pix.label;
		ent.hit = int'(pix.label) < NUM_LABELS;
		ent.last = pix.last_pixel;
		ent.query = pix.query_label;
		ent.query_hit = int'(pix.query_label) < NUM_LABELS;
	end

	assign pix_stall = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign push = pix_valid && !pix_stall;
	assign q_vld = (cnt_q != '0);
	assign do_pop = pop && q_vld;
	assign q_head = fifo_q[rd_ptr_q];

	// Store accepted requests
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= ent;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

### sv/plv_back.sv
// Back part: histogram update, end-of-patch scan, ratio test and result register.
module plv_back #(
	parameter int NUM_LABELS = 64,
	parameter int MAX_PATCH_PIXELS = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_vld,
	input  plv_pkg::plv_entry_t     q_head,
	output logic                    pop,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [plv_pkg::RATIO_W-1:0] cfg_data,
	output logic                    res_valid,
	input  logic                    res_stall,
	output plv_pkg::plv_res_t       res
);
	import plv_pkg::*;

	localparam int IDX_W = $clog2(NUM_LABELS);
	localparam int CNT_W = $clog2(MAX_PATCH_PIXELS + 1);
	localparam int PROD_W = CNT_W + RATIO_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LABELS - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PATCH_PIXELS);

	// Histogram memory and per-entry valid bits
	logic [CNT_W-1:0]      hist_mem [NUM_LABELS];
	logic [NUM_LABELS-1:0] seen_q;
	logic [CNT_W-1:0]      rd_q;

	plv_state_t            state_q;
	plv_state_t            state_nxt;
	logic                  scan_init;
	logic                  scan_issue;
	logic                  emit;

	// Count stage
	plv_entry_t            ent_s1;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [CNT_W-1:0]      cur_cnt;
	logic [CNT_W-1:0]      new_cnt;
	logic                  wr_en;
	logic [IDX_W-1:0]      fwd_idx_q;
	logic [CNT_W-1:0]      fwd_cnt_q;
	logic                  fwd_vld_q;

	// Scan stage
	logic [IDX_W-1:0]      scan_idx_q;
	logic [IDX_W-1:0]      scan_idx_s1;
	logic                  scan_vld_s1;
	logic [CNT_W-1:0]      scan_cnt;
	logic [CNT_W-1:0]      best_cnt_q;
	logic [IDX_W-1:0]      best_lbl_q;
	logic [CNT_W-1:0]      second_q;
	logic                  any_q;

	logic [RATIO_W-1:0]    ratio_q;
	logic [PROD_W-1:0]     prod_q;
	logic                  pass;
	logic                  present;
	logic                  res_vld_q;
	plv_res_t              res_q;

	assign cfg_ready = 1'b1;
	assign res_valid = res_vld_q;
	assign res = res_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_COUNT: begin
				if (q_vld && q_head.last) begin
					state_nxt = ST_LASTW;
				end
			end
			ST_LASTW: state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (scan_idx_q == LAST_IDX) begin
					state_nxt = ST_TAIL;
				end
			end
			ST_TAIL: state_nxt = ST_MUL;
			ST_MUL: state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (!res_vld_q || !res_stall) begin
					state_nxt = ST_COUNT;
				end
			end
			default: state_nxt = ST_COUNT;
		endcase
	end

	// State outputs
	always_comb begin
		pop = 1'b0;
		scan_init = 1'b0;
		scan_issue = 1'b0;
		emit = 1'b0;
		case (state_q)
			ST_COUNT: pop = q_vld;
			ST_LASTW: scan_init = 1'b1;
			ST_SCAN: scan_issue = 1'b1;
			ST_EMIT: emit = !res_vld_q || !res_stall;
			default: ;
		endcase
	end

	// Increment, saturating at MAX_PATCH_PIXELS, the counter of the request in the count stage; forward the last write
	always_comb begin
		idx_s1 = IDX_W'(ent_s1.label);
		if (fwd_vld_q && fwd_idx_q == idx_s1) begin
			cur_cnt = fwd_cnt_q;
		end else if (seen_q[idx_s1]) begin
			cur_cnt = rd_q;
		end else begin
			cur_cnt = '0;
		end
		new_cnt = (cur_cnt < CNT_MAX) ? cur_cnt + CNT_W'(1) : cur_cnt;
		wr_en = vld_s1 && ent_s1.hit;
	end

	// Histogram read and write port
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_q <= hist_mem[IDX_W'(q_head.label)];
		end else if (scan_issue) begin
			rd_q <= hist_mem[scan_idx_q];
		end
		if (wr_en) begin
			hist_mem[idx_s1] <= new_cnt;
		end
	end

	// Hold payload of the count stage and the forwarded write
	always_ff @(posedge clk) begin
		if (pop) begin
			ent_s1 <= q_head;
		end
		if (wr_en) begin
			fwd_idx_q <= idx_s1;
			fwd_cnt_q <= new_cnt;
		end
	end

	// Count-stage control, valid bits and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COUNT;
			vld_s1 <= 1'b0;
			fwd_vld_q <= 1'b0;
			seen_q <= '0;
		end else begin
			state_q <= state_nxt;
			vld_s1 <= pop;
			if (emit) begin
				seen_q <= '0;
				fwd_vld_q <= 1'b0;
			end else if (wr_en) begin
				seen_q[idx_s1] <= 1'b1;
				fwd_vld_q <= 1'b1;
			end
		end
	end

	assign scan_cnt = seen_q[scan_idx_s1] ? rd_q : '0;

	// Scan: one entry read per cycle, each compared in the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			scan_idx_s1 <= '0;
			scan_vld_s1 <= 1'b0;
			best_cnt_q <= '0;
			best_lbl_q <= '0;
			second_q <= '0;
			any_q <= 1'b0;
		end else begin
			scan_vld_s1 <= scan_issue;
			scan_idx_s1 <= scan_idx_q;
			if (scan_init) begin
				scan_idx_q <= '0;
				best_cnt_q <= '0;
				best_lbl_q <= '0;
				second_q <= '0;
				any_q <= 1'b0;
			end else begin
				if (scan_issue) begin
					scan_idx_q <= scan_idx_q + IDX_W'(1);
				end
				if (scan_vld_s1 && scan_cnt != '0) begin
					if (!any_q || scan_cnt > best_cnt_q) begin
						if (any_q) begin
							second_q <= best_cnt_q;
						end
						best_cnt_q <= scan_cnt;
						best_lbl_q <= scan_idx_s1;
						any_q <= 1'b1;
					end else if (scan_cnt > second_q) begin
						second_q <= scan_cnt;
					end
				end
			end
		end
	end

	// Ratio test product
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(best_cnt_q) * PROD_W'(ratio_q);
		end
	end

	assign pass = any_q && (prod_q >= (PROD_W'(second_q) << RATIO_FRAC_W));
	assign present = ent_s1.query_hit && seen_q[IDX_W'(ent_s1.query)];

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ratio_q <= cfg_data;
		end
	end

	// Result register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (emit) begin
			res_vld_q <= 1'b1;
		end else if (res_vld_q && !res_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.top_label <= LABEL_W'(best_lbl_q);
			res_q.ratio_pass <= pass;
			res_q.query_present <= present;
			res_q.top_count <= COUNT_OUT_W'(best_cnt_q);
		end
	end

endmodule

### sv/patch_label_vote.sv
// Throughput: one pixel request per cycle while a patch is being counted.
// After a last pixel is taken from the queue, the block passes through ST_LASTW, ST_SCAN,
// ST_TAIL, ST_MUL and ST_EMIT before the result loads; the scan reads one histogram entry
// per cycle through the memory's single read port, and intake stalls once the two-entry
// queue fills during the scan. Reset: asynchronous, active low; clears the histogram valid
// bits, queue and result valid flag, and sets the ratio register to 1.0.
module patch_label_vote #(
	parameter int NUM_LABELS = plv_pkg::NUM_LABELS_DEF,
	parameter int MAX_PATCH_PIXELS = plv_pkg::MAX_PATCH_PIXELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	output logic                        pix_stall,
	input  plv_pkg::plv_pix_t           pix,
	output logic                        res_valid,
	input  logic                        res_stall,
	output plv_pkg::plv_res_t           res,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [plv_pkg::RATIO_W-1:0] cfg_data
);
	import plv_pkg::*;

	plv_entry_t q_head;
	logic       q_vld;
	logic       pop;

	// Classify and queue pixel requests
	plv_front #(
		.NUM_LABELS(NUM_LABELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix      (pix),
		.q_vld    (q_vld),
		.q_head   (q_head),
		.pop      (pop)
	);

	// Count, scan and report
	plv_back #(
		.NUM_LABELS      (NUM_LABELS),
		.MAX_PATCH_PIXELS(MAX_PATCH_PIXELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_vld    (q_vld),
		.q_head   (q_head),
		.pop      (pop),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule

### sv/plv_checker.sv
// Port-level checks for the patch label vote block, bound to its top level.
module plv_checker #(
	parameter int MAX_PATCH_PIXELS = 1024
) (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_stall,
	input plv_pkg::plv_res_t res
);
	import plv_pkg::*;

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// An empty patch reports label zero, nothing present and no pass
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.top_count == '0 |->
			!res.ratio_pass && !res.query_present && res.top_label == '0)
		else $error("empty patch result inconsistent");

	// Counts never exceed the saturation limit
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> int'(res.top_count) <= MAX_PATCH_PIXELS)
		else $error("top count above limit");

	// A present query means at least one pixel was counted
	a_present_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.query_present |-> res.top_count != '0)
		else $error("present query with empty histogram");

endmodule

bind patch_label_vote plv_checker #(
	.MAX_PATCH_PIXELS(MAX_PATCH_PIXELS)
) u_plv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res      (res)
);
